@@ rtl/ring_collective_completion_tracker_top_defines.svh @@
// Assertion macros shared by the checker of the ring collective completion tracker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef RING_COLLECTIVE_COMPLETION_TRACKER_TOP_DEFINES_SVH
`define RING_COLLECTIVE_COMPLETION_TRACKER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcct: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RCCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcct: next-cycle check failed");

`endif

@@ rtl/rcct_pkg.sv @@
// Shared types, codes and constants of the ring collective completion tracker.
// No dependencies; used by the controller, the datapath, the top level and the checker.
package rcct_pkg;

  // Field widths fixed by the interface.
  localparam int CNT_W       = 11;
  localparam int TAG_W       = 10;
  localparam int PEER_W      = 8;
  localparam int KIND_W      = 3;
  localparam int CMD_W       = 2;
  localparam int REG_W       = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int RES_CNT_W   = 4;
  localparam int MAX_RESULTS = 16;

  // Largest message count the 11-bit register can hold.
  localparam int MSG_LIMIT = 2047;

  // Default sizing.
  localparam int DEF_QUEUE_PAIRS = 2;
  localparam int DEF_INFLIGHT    = 4;
  localparam int DEF_MAX_MSGS    = 1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_START    = 2'd0,
    CMD_SEND_CPL = 2'd1,
    CMD_RECV_CPL = 2'd2
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_POST_SEND  = 3'd0,
    KIND_POST_RECV  = 3'd1,
    KIND_ALL_DONE   = 3'd2,
    KIND_SPURIOUS   = 3'd3,
    KIND_OVER_COUNT = 3'd4
  } kind_e;

  typedef enum logic [REG_W-1:0] {
    REG_MSGS_PER_QUEUE = 2'd0,
    REG_SEND_PEER      = 2'd1,
    REG_RECV_PEER      = 2'd2
  } reg_e;

  // Which result the datapath loads into the output register.
  typedef enum logic [2:0] {
    EMIT_SEND       = 3'd0,
    EMIT_RECV       = 3'd1,
    EMIT_DONE       = 3'd2,
    EMIT_SPUR_START = 3'd3,
    EMIT_SPUR_QP    = 3'd4,
    EMIT_SPUR_IDX   = 3'd5,
    EMIT_OVER       = 3'd6
  } emit_sel_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_POST_SEND,
    ST_POST_RECV,
    ST_EVAL,
    ST_CPL_SEND
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      clr_en;
    logic      load;
    logic      emit;
    emit_sel_e emit_sel;
    logic      emit_last;
    logic      loop_step;
    logic      commit;
    logic      finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic out_free;
    logic any_posted;
    logic cnt_zero;
    logic res_full;
    logic loop_end;
    logic q_bad;
    logic idx_spur;
    logic finishing;
    logic all_fin;
    logic over;
    logic need_recv;
    logic need_send;
  } dp_status_t;

endpackage

@@ rtl/rcct_ctrl.sv @@
// Controller state machine of the ring collective completion tracker.
// Depends on rcct_pkg; drives the datapath with dp_cmd_t and reads dp_status_t.
module rcct_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_valid_i,
  output logic                         s_ready_o,
  input  logic [rcct_pkg::CMD_W-1:0]   s_cmd_i,
  input  rcct_pkg::dp_status_t         status_i,
  output rcct_pkg::dp_cmd_t            ctl_o
);

  rcct_pkg::state_e state_q, state_d;

  // State register; the mark store is swept clear right after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcct_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rcct_pkg::ST_CLEAR: begin
        if (status_i.clr_last) state_d = rcct_pkg::ST_IDLE;
      end
      rcct_pkg::ST_IDLE: begin
        if (s_valid_i) begin
          unique case (s_cmd_i)
            rcct_pkg::CMD_START:    state_d = rcct_pkg::ST_START;
            rcct_pkg::CMD_SEND_CPL: state_d = rcct_pkg::ST_EVAL;
            rcct_pkg::CMD_RECV_CPL: state_d = rcct_pkg::ST_EVAL;
            default:                state_d = rcct_pkg::ST_IDLE;
          endcase
        end
      end
      rcct_pkg::ST_START: begin
        if (status_i.any_posted) begin
          if (status_i.out_free) state_d = rcct_pkg::ST_IDLE;
        end else if (status_i.cnt_zero) begin
          state_d = rcct_pkg::ST_IDLE;
        end else begin
          state_d = rcct_pkg::ST_POST_SEND;
        end
      end
      rcct_pkg::ST_POST_SEND: begin
        if (status_i.out_free) begin
          state_d = status_i.res_full ? rcct_pkg::ST_IDLE : rcct_pkg::ST_POST_RECV;
        end
      end
      rcct_pkg::ST_POST_RECV: begin
        if (status_i.out_free) begin
          state_d = (status_i.res_full || status_i.loop_end) ? rcct_pkg::ST_IDLE
                                                               : rcct_pkg::ST_POST_SEND;
        end
      end
      rcct_pkg::ST_EVAL: begin
        if (status_i.q_bad || status_i.idx_spur) begin
          if (status_i.out_free) state_d = rcct_pkg::ST_IDLE;
        end else if (status_i.finishing) begin
          if (!status_i.all_fin || status_i.out_free) state_d = rcct_pkg::ST_IDLE;
        end else if (status_i.over) begin
          if (status_i.out_free) state_d = rcct_pkg::ST_IDLE;
        end else if (status_i.need_recv || status_i.need_send) begin
          if (status_i.out_free) begin
            state_d = (status_i.need_recv && status_i.need_send) ? rcct_pkg::ST_CPL_SEND
                                                                   : rcct_pkg::ST_IDLE;
          end
        end else begin
          state_d = rcct_pkg::ST_IDLE;
        end
      end
      rcct_pkg::ST_CPL_SEND: begin
        if (status_i.out_free) state_d = rcct_pkg::ST_IDLE;
      end
      default: state_d = rcct_pkg::ST_IDLE;
    endcase
  end

  // Output logic: one datapath command set per cycle.
  always_comb begin
    ctl_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      rcct_pkg::ST_CLEAR: begin
        ctl_o.clr_en = 1'b1;
      end
      rcct_pkg::ST_IDLE: begin
        s_ready_o  = 1'b1;
        ctl_o.load = s_valid_i;
      end
      rcct_pkg::ST_START: begin
        if (status_i.any_posted && status_i.out_free) begin
          ctl_o.emit      = 1'b1;
          ctl_o.emit_sel  = rcct_pkg::EMIT_SPUR_START;
          ctl_o.emit_last = 1'b1;
        end
      end
      rcct_pkg::ST_POST_SEND: begin
        if (status_i.out_free) begin
          ctl_o.emit      = 1'b1;
          ctl_o.emit_sel  = rcct_pkg::EMIT_SEND;
          ctl_o.emit_last = status_i.res_full;
        end
      end
      rcct_pkg::ST_POST_RECV: begin
        if (status_i.out_free) begin
          ctl_o.emit      = 1'b1;
          ctl_o.emit_sel  = rcct_pkg::EMIT_RECV;
          ctl_o.emit_last = status_i.res_full || status_i.loop_end;
          ctl_o.loop_step = !(status_i.res_full || status_i.loop_end);
        end
      end
      rcct_pkg::ST_EVAL: begin
        if (status_i.q_bad) begin
          if (status_i.out_free) begin
            ctl_o.emit      = 1'b1;
            ctl_o.emit_sel  = rcct_pkg::EMIT_SPUR_QP;
            ctl_o.emit_last = 1'b1;
          end
        end else if (status_i.idx_spur) begin
          if (status_i.out_free) begin
            ctl_o.emit      = 1'b1;
            ctl_o.emit_sel  = rcct_pkg::EMIT_SPUR_IDX;
            ctl_o.emit_last = 1'b1;
          end
        end else if (status_i.finishing) begin
          if (!status_i.all_fin) begin
            ctl_o.finish = 1'b1;
          end else if (status_i.out_free) begin
            ctl_o.finish    = 1'b1;
            ctl_o.emit      = 1'b1;
            ctl_o.emit_sel  = rcct_pkg::EMIT_DONE;
            ctl_o.emit_last = 1'b1;
          end
        end else if (status_i.over) begin
          if (status_i.out_free) begin
            ctl_o.emit      = 1'b1;
            ctl_o.emit_sel  = rcct_pkg::EMIT_OVER;
            ctl_o.emit_last = 1'b1;
          end
        end else if (status_i.need_recv || status_i.need_send) begin
          if (status_i.out_free) begin
            ctl_o.commit    = 1'b1;
            ctl_o.emit      = 1'b1;
            ctl_o.emit_sel  = status_i.need_recv ? rcct_pkg::EMIT_RECV : rcct_pkg::EMIT_SEND;
            ctl_o.emit_last = !(status_i.need_recv && status_i.need_send);
          end
        end else begin
          ctl_o.commit = 1'b1;
        end
      end
      rcct_pkg::ST_CPL_SEND: begin
        if (status_i.out_free) begin
          ctl_o.emit      = 1'b1;
          ctl_o.emit_sel  = rcct_pkg::EMIT_SEND;
          ctl_o.emit_last = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/rcct_datapath.sv @@
// Datapath of the ring collective completion tracker: configuration, counters,
// message mark store and output register. Depends on rcct_pkg.
module rcct_datapath #(
  parameter int QUEUE_PAIRS = rcct_pkg::DEF_QUEUE_PAIRS,
  parameter int INFLIGHT    = rcct_pkg::DEF_INFLIGHT,
  parameter int MAX_MSGS    = rcct_pkg::DEF_MAX_MSGS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [rcct_pkg::REG_W-1:0]        cfg_addr_i,
  input  logic [rcct_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [rcct_pkg::CMD_W-1:0]        s_cmd_i,
  input  logic                              s_qp_i,
  input  rcct_pkg::dp_cmd_t                 ctl_i,
  output rcct_pkg::dp_status_t              status_o,
  output logic                              m_valid_o,
  input  logic                              m_ready_i,
  output logic [rcct_pkg::KIND_W-1:0]       m_kind_o,
  output logic                              m_queue_o,
  output logic [rcct_pkg::TAG_W-1:0]        m_tag_o,
  output logic [rcct_pkg::PEER_W-1:0]       m_peer_o,
  output logic                              m_last_o
);

  localparam int CW        = rcct_pkg::CNT_W;
  localparam int QW        = (QUEUE_PAIRS > 1) ? $clog2(QUEUE_PAIRS) : 1;
  localparam int RND_W     = (INFLIGHT > 1) ? $clog2(INFLIGHT) : 1;
  localparam int MSG_CAP   = (MAX_MSGS < rcct_pkg::MSG_LIMIT) ? MAX_MSGS : rcct_pkg::MSG_LIMIT;
  localparam int IDX_W     = (MSG_CAP > 1) ? $clog2(MSG_CAP) : 1;
  localparam int AW        = QW + IDX_W;
  localparam int MEM_DEPTH = 1 << AW;

  // Configuration registers; the port is always ready.
  logic [CW-1:0]                  msgs_q;
  logic [rcct_pkg::PEER_W-1:0]    send_peer_q;
  logic [rcct_pkg::PEER_W-1:0]    recv_peer_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msgs_q      <= '0;
      send_peer_q <= rcct_pkg::PEER_W'(1);
      recv_peer_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        rcct_pkg::REG_MSGS_PER_QUEUE: msgs_q      <= cfg_data_i;
        rcct_pkg::REG_SEND_PEER:      send_peer_q <= cfg_data_i[rcct_pkg::PEER_W-1:0];
        rcct_pkg::REG_RECV_PEER:      recv_peer_q <= cfg_data_i[rcct_pkg::PEER_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective message count and start window.
  logic [CW-1:0] eff;
  logic [CW-1:0] cnt;
  assign eff = (msgs_q > CW'(MSG_CAP)) ? CW'(MSG_CAP) : msgs_q;
  assign cnt = (eff < CW'(INFLIGHT)) ? eff : CW'(INFLIGHT);

  // Per-queue state.
  logic [CW-1:0]          sp_q [QUEUE_PAIRS];
  logic [CW-1:0]          rp_q [QUEUE_PAIRS];
  logic [CW-1:0]          sc_q [QUEUE_PAIRS];
  logic [CW-1:0]          rc_q [QUEUE_PAIRS];
  logic [QUEUE_PAIRS-1:0] fin_q;

  // Request context latched at acceptance.
  logic [rcct_pkg::CMD_W-1:0]     cmd_q;
  logic                           qp_q;
  logic [AW-1:0]                  addr_q;
  logic [RND_W-1:0]               round_q;
  logic [QW-1:0]                  lq_q;
  logic [rcct_pkg::RES_CNT_W-1:0] res_cnt_q;
  logic [1:0]                     mark_rd_q;
  logic [AW-1:0]                  clr_addr_q;
  logic [1:0]                     marks_q [MEM_DEPTH];

  // Address of the mark that the incoming request touches.
  logic [QW-1:0] in_q;
  logic [CW-1:0] in_idx;
  logic [AW-1:0] in_addr;
  assign in_q    = (32'(s_qp_i) < 32'(QUEUE_PAIRS)) ? QW'(s_qp_i) : '0;
  assign in_idx  = (s_cmd_i == rcct_pkg::CMD_RECV_CPL) ? rc_q[in_q] : sc_q[in_q];
  assign in_addr = {in_q, in_idx[IDX_W-1:0]};

  // Queue selected for the current request.
  logic          is_start;
  logic          is_recv;
  logic          q_bad;
  logic [QW-1:0] q_sel;
  assign is_start = (cmd_q == rcct_pkg::CMD_START);
  assign is_recv  = (cmd_q == rcct_pkg::CMD_RECV_CPL);
  assign q_bad    = (32'(qp_q) >= 32'(QUEUE_PAIRS));
  assign q_sel    = is_start ? lq_q : (q_bad ? '0 : QW'(qp_q));

  // Completion evaluation.
  logic [CW-1:0] idx;
  logic [CW-1:0] ns;
  logic [CW-1:0] nr;
  assign idx = is_recv ? rc_q[q_sel] : sc_q[q_sel];
  assign ns  = sc_q[q_sel] + CW'(!is_recv);
  assign nr  = rc_q[q_sel] + CW'(is_recv);

  logic all_fin;
  logic any_posted;
  always_comb begin
    all_fin    = 1'b1;
    any_posted = 1'b0;
    for (int i = 0; i < QUEUE_PAIRS; i++) begin
      if (!fin_q[i] && (QW'(i) != q_sel)) all_fin = 1'b0;
      if ((sp_q[i] != '0) || (rp_q[i] != '0)) any_posted = 1'b1;
    end
  end

  // Status toward the controller.
  assign status_o.clr_last   = &clr_addr_q;
  assign status_o.out_free   = !m_valid_o || m_ready_i;
  assign status_o.any_posted = any_posted;
  assign status_o.cnt_zero   = (cnt == '0);
  assign status_o.res_full   = &res_cnt_q;
  assign status_o.loop_end   = (CW'(round_q) == (cnt - CW'(1)))
                               && (32'(lq_q) == 32'(QUEUE_PAIRS - 1));
  assign status_o.q_bad      = q_bad;
  assign status_o.idx_spur   = (idx >= eff);
  assign status_o.finishing  = (ns == eff) && (nr == eff);
  assign status_o.all_fin    = all_fin;
  assign status_o.over       = mark_rd_q[1];
  assign status_o.need_recv  = is_recv && (rp_q[q_sel] < eff);
  assign status_o.need_send  = (mark_rd_q == 2'd1) && (sp_q[q_sel] < eff);

  // Posted and completed counters, finished flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QUEUE_PAIRS; i++) begin
        sp_q[i] <= '0;
        rp_q[i] <= '0;
        sc_q[i] <= '0;
        rc_q[i] <= '0;
      end
      fin_q <= '0;
    end else begin
      if (ctl_i.emit && (ctl_i.emit_sel == rcct_pkg::EMIT_SEND)) begin
        sp_q[q_sel] <= sp_q[q_sel] + CW'(1);
      end
      if (ctl_i.emit && (ctl_i.emit_sel == rcct_pkg::EMIT_RECV)) begin
        rp_q[q_sel] <= rp_q[q_sel] + CW'(1);
      end
      if (ctl_i.commit || ctl_i.finish) begin
        sc_q[q_sel] <= ns;
        rc_q[q_sel] <= nr;
      end
      if (ctl_i.finish) begin
        fin_q[q_sel] <= 1'b1;
      end
    end
  end

  // Request context and start loop indices.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q     <= rcct_pkg::CMD_START;
      qp_q      <= 1'b0;
      addr_q    <= '0;
      round_q   <= '0;
      lq_q      <= '0;
      res_cnt_q <= '0;
    end else if (ctl_i.load) begin
      cmd_q     <= s_cmd_i;
      qp_q      <= s_qp_i;
      addr_q    <= in_addr;
      round_q   <= '0;
      lq_q      <= '0;
      res_cnt_q <= '0;
    end else begin
      if (ctl_i.emit) res_cnt_q <= res_cnt_q + rcct_pkg::RES_CNT_W'(1);
      if (ctl_i.loop_step) begin
        if (32'(lq_q) == 32'(QUEUE_PAIRS - 1)) begin
          lq_q    <= '0;
          round_q <= round_q + RND_W'(1);
        end else begin
          lq_q <= lq_q + QW'(1);
        end
      end
    end
  end

  // Clearing sweep address after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (ctl_i.clr_en) begin
      clr_addr_q <= clr_addr_q + AW'(1);
    end
  end

  // Mark store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.clr_en) begin
      marks_q[clr_addr_q] <= 2'd0;
    end else if (ctl_i.commit) begin
      marks_q[addr_q] <= mark_rd_q + 2'd1;
    end
    if (ctl_i.load) begin
      mark_rd_q <= marks_q[in_addr];
    end
  end

  // Result payload selection.
  logic [rcct_pkg::KIND_W-1:0] kind_d;
  logic                        queue_d;
  logic [rcct_pkg::TAG_W-1:0]  tag_d;
  logic [rcct_pkg::PEER_W-1:0] peer_d;

  always_comb begin
    kind_d  = rcct_pkg::KIND_SPURIOUS;
    queue_d = q_sel[0];
    tag_d   = '0;
    peer_d  = '0;
    case (ctl_i.emit_sel)
      rcct_pkg::EMIT_SEND: begin
        kind_d = rcct_pkg::KIND_POST_SEND;
        tag_d  = sp_q[q_sel][rcct_pkg::TAG_W-1:0];
        peer_d = send_peer_q;
      end
      rcct_pkg::EMIT_RECV: begin
        kind_d = rcct_pkg::KIND_POST_RECV;
        tag_d  = rp_q[q_sel][rcct_pkg::TAG_W-1:0];
        peer_d = recv_peer_q;
      end
      rcct_pkg::EMIT_DONE: begin
        kind_d = rcct_pkg::KIND_ALL_DONE;
      end
      rcct_pkg::EMIT_SPUR_START: begin
        queue_d = 1'b0;
      end
      rcct_pkg::EMIT_SPUR_QP: begin
        queue_d = qp_q;
      end
      rcct_pkg::EMIT_SPUR_IDX: begin
        queue_d = qp_q;
        tag_d   = idx[rcct_pkg::TAG_W-1:0];
      end
      rcct_pkg::EMIT_OVER: begin
        kind_d  = rcct_pkg::KIND_OVER_COUNT;
        queue_d = qp_q;
        tag_d   = idx[rcct_pkg::TAG_W-1:0];
      end
      default: ;
    endcase
  end

  // Output register.
  logic                        m_valid_q;
  logic [rcct_pkg::KIND_W-1:0] m_kind_q;
  logic                        m_queue_q;
  logic [rcct_pkg::TAG_W-1:0]  m_tag_q;
  logic [rcct_pkg::PEER_W-1:0] m_peer_q;
  logic                        m_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (ctl_i.emit) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      m_kind_q  <= kind_d;
      m_queue_q <= queue_d;
      m_tag_q   <= tag_d;
      m_peer_q  <= peer_d;
      m_last_q  <= ctl_i.emit_last;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_kind_o  = m_kind_q;
  assign m_queue_o = m_queue_q;
  assign m_tag_o   = m_tag_q;
  assign m_peer_o  = m_peer_q;
  assign m_last_o  = m_last_q;

endmodule

@@ rtl/ring_collective_completion_tracker_top.sv @@
// Top level of the ring collective completion tracker.
// Depends on rcct_pkg, rcct_ctrl and rcct_datapath.
//
//   Channel   Direction  Handshake               Payload
//   s_*       in         s_tvalid_i/s_tready_o   tuser: cmd; tdata: qp
//   m_*       out        m_tvalid_o/m_tready_i   tuser: kind; tdata: queue, tag, peer; tlast
//   cfg_*     in         cfg_valid_i/cfg_ready_o register index, write data
//
// A completion is accepted with its mark read, then updated in the evaluation state; a
// second post adds the send-completion state. The mark store read-modify-write sets this order.
// A start enters the start state, then posts its results in turn or reports a spurious start.
// After reset the mark store is swept clear, one entry a cycle, over every entry of the
// store, addressed by queue index bits plus message index bits (2048 by default).
// A stalled output holds the controller; a new request is taken while the last
// result still waits in the output register. Configuration is always ready.
module ring_collective_completion_tracker_top #(
  parameter int QUEUE_PAIRS = rcct_pkg::DEF_QUEUE_PAIRS,
  parameter int INFLIGHT    = rcct_pkg::DEF_INFLIGHT,
  parameter int MAX_MSGS    = rcct_pkg::DEF_MAX_MSGS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Request stream.
  input  logic                             s_tvalid_i,
  output logic                             s_tready_o,
  input  logic [rcct_pkg::CMD_W-1:0]       s_tuser_i,   // cmd[1:0]
  input  logic [7:0]                       s_tdata_i,   // qp[0], zero[7:1]
  // Result stream.
  output logic                             m_tvalid_o,
  input  logic                             m_tready_i,
  output logic [rcct_pkg::KIND_W-1:0]      m_tuser_o,   // kind[2:0]
  output logic [23:0]                      m_tdata_o,   // queue[0], tag[10:1], peer[18:11],
                                                        // zero[23:19]
  output logic                             m_tlast_o,
  // Configuration writes.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rcct_pkg::REG_W-1:0]       cfg_addr_i,
  input  logic [rcct_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  rcct_pkg::dp_cmd_t    ctl;
  rcct_pkg::dp_status_t status;

  logic                        m_queue;
  logic [rcct_pkg::TAG_W-1:0]  m_tag;
  logic [rcct_pkg::PEER_W-1:0] m_peer;

  // Controller.
  rcct_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_tvalid_i),
    .s_ready_o (s_tready_o),
    .s_cmd_i   (s_tuser_i),
    .status_i  (status),
    .ctl_o     (ctl)
  );

  // Datapath.
  rcct_datapath #(
    .QUEUE_PAIRS (QUEUE_PAIRS),
    .INFLIGHT    (INFLIGHT),
    .MAX_MSGS    (MAX_MSGS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .s_cmd_i     (s_tuser_i),
    .s_qp_i      (s_tdata_i[0]),
    .ctl_i       (ctl),
    .status_o    (status),
    .m_valid_o   (m_tvalid_o),
    .m_ready_i   (m_tready_i),
    .m_kind_o    (m_tuser_o),
    .m_queue_o   (m_queue),
    .m_tag_o     (m_tag),
    .m_peer_o    (m_peer),
    .m_last_o    (m_tlast_o)
  );

  // Pack the result fields.
  assign m_tdata_o   = {5'b00000, m_peer, m_tag, m_queue};
  assign cfg_ready_o = 1'b1;

endmodule

@@ rtl/rcct_checker.sv @@
// Port-level checks of the ring collective completion tracker, bound to the top.
// Depends on rcct_pkg and ring_collective_completion_tracker_top_defines.svh.
`include "ring_collective_completion_tracker_top_defines.svh"

module rcct_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_tvalid_i,
  input logic                          s_tready_o,
  input logic [rcct_pkg::CMD_W-1:0]    s_tuser_i,
  input logic                          m_tvalid_o,
  input logic                          m_tready_i,
  input logic [rcct_pkg::KIND_W-1:0]   m_tuser_o,
  input logic [23:0]                   m_tdata_o,
  input logic                          m_tlast_o
);

  logic out_stall;
  logic kind_ok;
  logic solo_kind;
  logic solo_ok;
  logic busy_req;

  // Terms shared by the checks below.
  assign out_stall = m_tvalid_o && !m_tready_i;
  assign kind_ok   = (m_tuser_o <= rcct_pkg::KIND_OVER_COUNT) && (m_tdata_o[23:19] == 5'd0);
  assign solo_kind = m_tvalid_o && ((m_tuser_o == rcct_pkg::KIND_ALL_DONE)
                                    || (m_tuser_o == rcct_pkg::KIND_SPURIOUS)
                                    || (m_tuser_o == rcct_pkg::KIND_OVER_COUNT));
  assign solo_ok   = m_tlast_o && (m_tdata_o[18:11] == 8'd0);
  assign busy_req  = s_tvalid_i && s_tready_o && ((s_tuser_i == rcct_pkg::CMD_START)
                                                  || (s_tuser_i == rcct_pkg::CMD_SEND_CPL)
                                                  || (s_tuser_i == rcct_pkg::CMD_RECV_CPL));

  // A stalled result holds its contents.
  `RCCT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, m_tvalid_o && $stable({m_tuser_o, m_tdata_o, m_tlast_o}))

  // Only defined result kinds appear, with the pad bits clear.
  `RCCT_ASSERT_IMP(a_kind_legal, clk_i, rst_ni, m_tvalid_o, kind_ok)

  // Done and error results stand alone and carry no peer.
  `RCCT_ASSERT_IMP(a_single_result, clk_i, rst_ni, solo_kind, solo_ok)

  // A start or completion request keeps the input closed for the next cycle.
  `RCCT_ASSERT_NXT(a_busy_after_req, clk_i, rst_ni, busy_req, !s_tready_o)

endmodule

bind ring_collective_completion_tracker_top rcct_checker u_rcct_checker (.*);

@@ tb/tb_ring_collective_completion_tracker_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the ring collective completion tracker top level.
// Depends on rcct_pkg and ring_collective_completion_tracker_top; predicts every result.
module tb_ring_collective_completion_tracker_top;

  localparam int NQ             = rcct_pkg::DEF_QUEUE_PAIRS;
  localparam int INFL           = rcct_pkg::DEF_INFLIGHT;
  localparam int MSG_CAP        = rcct_pkg::DEF_MAX_MSGS;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int CNT_W          = rcct_pkg::CNT_W;
  localparam int TAG_W          = rcct_pkg::TAG_W;
  localparam int PEER_W         = rcct_pkg::PEER_W;
  localparam int CMD_W          = rcct_pkg::CMD_W;
  localparam int CFG_DATA_W     = rcct_pkg::CFG_DATA_W;
  localparam int MAX_RESULTS    = rcct_pkg::MAX_RESULTS;

  // The one command code the block has no use for.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    rcct_pkg::kind_e   kind;
    logic              queue;
    logic [TAG_W-1:0]  tag;
    logic [PEER_W-1:0] peer;
    logic              last;
  } tracker_result_t;

  logic                           clk_i       = 1'b0;
  logic                           rst_n       = 1'b0;
  logic                           s_tvalid    = 1'b0;
  logic                           s_tready_o;
  logic [CMD_W-1:0]               s_tuser     = '0;
  logic [7:0]                     s_tdata     = '0;
  logic                           m_tvalid_o;
  logic                           m_tready    = 1'b0;
  logic [rcct_pkg::KIND_W-1:0]    m_tuser_o;
  logic [23:0]                    m_tdata_o;
  logic                           m_tlast_o;
  logic                           cfg_valid   = 1'b0;
  logic                           cfg_ready_o;
  logic [rcct_pkg::REG_W-1:0]     cfg_addr    = '0;
  logic [CFG_DATA_W-1:0]          cfg_data    = '0;

  ring_collective_completion_tracker_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .s_tvalid_i  (s_tvalid),
    .s_tready_o  (s_tready_o),
    .s_tuser_i   (s_tuser),
    .s_tdata_i   (s_tdata),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready),
    .m_tuser_o   (m_tuser_o),
    .m_tdata_o   (m_tdata_o),
    .m_tlast_o   (m_tlast_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the tracker: registers, counters and per-message marks.
  bit [CNT_W-1:0]  msgs_reg;
  bit [PEER_W-1:0] send_peer_reg;
  bit [PEER_W-1:0] recv_peer_reg;
  bit [CNT_W-1:0]  sends_posted [NQ];
  bit [CNT_W-1:0]  recvs_posted [NQ];
  bit [CNT_W-1:0]  sends_done   [NQ];
  bit [CNT_W-1:0]  recvs_done   [NQ];
  bit [NQ-1:0]     queue_fin;
  bit [1:0]        msg_marks    [NQ][MSG_CAP];

  tracker_result_t step_res [MAX_RESULTS];
  int              step_n;
  tracker_result_t due_results [$];
  logic [CMD_W:0]  request_backlog [$];
  int              requests_queued = 0;
  int              requests_taken  = 0;
  int              sender_idle_pct = 0;
  int              receiver_stall_pct = 0;
  int              mismatches = 0;
  int              quiet_cycles = 0;

  function automatic logic [CNT_W-1:0] msg_count();
    return (msgs_reg > MSG_CAP) ? CNT_W'(MSG_CAP) : msgs_reg;
  endfunction

  function automatic string fmt_result(tracker_result_t r);
    return $sformatf("kind=%0d queue=%0d tag=%0d peer=%0d last=%0d",
                     r.kind, r.queue, r.tag, r.peer, r.last);
  endfunction

  task automatic add_result(rcct_pkg::kind_e k, logic q, logic [TAG_W-1:0] tag,
                            logic [PEER_W-1:0] peer);
    if (step_n < MAX_RESULTS) begin
      step_res[step_n] = '{kind: k, queue: q, tag: tag, peer: peer, last: 1'b0};
      step_n++;
    end
  endtask

  // A start posts up to INFLIGHT send/receive pairs per queue, queue by queue in each round.
  task automatic start_collective();
    logic [CNT_W-1:0] rounds;
    rounds = (msg_count() < INFL) ? msg_count() : CNT_W'(INFL);
    for (int q = 0; q < NQ; q++) begin
      if (sends_posted[q] != 0 || recvs_posted[q] != 0) begin
        add_result(rcct_pkg::KIND_SPURIOUS, 1'b0, '0, '0);
        return;
      end
    end
    for (int i = 0; i < rounds; i++) begin
      for (int q = 0; q < NQ; q++) begin
        if (step_n >= MAX_RESULTS) return;
        add_result(rcct_pkg::KIND_POST_SEND, q[0], sends_posted[q][TAG_W-1:0], send_peer_reg);
        sends_posted[q]++;
        if (step_n >= MAX_RESULTS) return;
        add_result(rcct_pkg::KIND_POST_RECV, q[0], recvs_posted[q][TAG_W-1:0], recv_peer_reg);
        recvs_posted[q]++;
      end
    end
  endtask

  // A completion advances its counter and the message mark; the second mark frees a send.
  task automatic complete_request(logic q, logic is_recv);
    logic [CNT_W-1:0] m;
    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] ns;
    logic [CNT_W-1:0] nr;
    m   = msg_count();
    idx = is_recv ? recvs_done[q] : sends_done[q];
    if (idx >= m) begin
      add_result(rcct_pkg::KIND_SPURIOUS, q, idx[TAG_W-1:0], '0);
      return;
    end
    ns = sends_done[q] + CNT_W'(!is_recv);
    nr = recvs_done[q] + CNT_W'(is_recv);
    // The closing completion of a queue neither marks nor reposts.
    if (ns == m && nr == m) begin
      sends_done[q] = ns;
      recvs_done[q] = nr;
      queue_fin[q]  = 1'b1;
      if (&queue_fin) add_result(rcct_pkg::KIND_ALL_DONE, q, '0, '0);
      return;
    end
    if (msg_marks[q][idx[TAG_W-1:0]] >= 2) begin
      add_result(rcct_pkg::KIND_OVER_COUNT, q, idx[TAG_W-1:0], '0);
      return;
    end
    sends_done[q] = ns;
    recvs_done[q] = nr;
    if (is_recv && recvs_posted[q] < m) begin
      add_result(rcct_pkg::KIND_POST_RECV, q, recvs_posted[q][TAG_W-1:0], recv_peer_reg);
      recvs_posted[q]++;
    end
    msg_marks[q][idx[TAG_W-1:0]]++;
    if (msg_marks[q][idx[TAG_W-1:0]] == 2 && sends_posted[q] < m) begin
      add_result(rcct_pkg::KIND_POST_SEND, q, sends_posted[q][TAG_W-1:0], send_peer_reg);
      sends_posted[q]++;
    end
  endtask

  task automatic track_request(logic [CMD_W-1:0] cmd, logic qp);
    step_n = 0;
    case (cmd)
      rcct_pkg::CMD_START:    start_collective();
      rcct_pkg::CMD_SEND_CPL: complete_request(qp, 1'b0);
      rcct_pkg::CMD_RECV_CPL: complete_request(qp, 1'b1);
      default: ;  // The unused command code is dropped without a result.
    endcase
    if (step_n > 0) step_res[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++) due_results.push_back(step_res[i]);
  endtask

  task automatic queue_request(logic [CMD_W-1:0] cmd, logic qp);
    request_backlog.push_back({qp, cmd});
    requests_queued++;
  endtask

  // Starts at a rising edge; leaves valid high so that writes can follow back to back.
  task automatic write_reg(rcct_pkg::reg_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      rcct_pkg::REG_MSGS_PER_QUEUE: msgs_reg      = val;
      rcct_pkg::REG_SEND_PEER:      send_peer_reg = val[PEER_W-1:0];
      rcct_pkg::REG_RECV_PEER:      recv_peer_reg = val[PEER_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_quiet();
    while (requests_taken != requests_queued || due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly completions of requests already posted, in batches, with some random noise.
  task automatic run_traffic(int count);
    int               batch;
    int               q;
    logic [CMD_W-1:0] cmd;
    logic             send_ok;
    logic             recv_ok;
    logic [CNT_W-1:0] m;
    bit [CNT_W-1:0]   sc [NQ];
    bit [CNT_W-1:0]   rc [NQ];
    bit [CNT_W-1:0]   sp [NQ];
    bit [CNT_W-1:0]   rp [NQ];
    while (count > 0) begin
      batch = $urandom_range(1, 8);
      if (batch > count) batch = count;
      count -= batch;
      m  = msg_count();
      sc = sends_done;
      rc = recvs_done;
      sp = sends_posted;
      rp = recvs_posted;
      repeat (batch) begin
        if ($urandom_range(0, 99) < 15) begin
          queue_request(CMD_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        end else begin
          q       = $urandom_range(0, NQ - 1);
          cmd     = ($urandom_range(0, 1) == 0) ? rcct_pkg::CMD_SEND_CPL
                                                : rcct_pkg::CMD_RECV_CPL;
          send_ok = 1'b0;
          recv_ok = 1'b0;
          for (int t = 0; t < NQ; t++) begin
            send_ok = sc[q] < sp[q] && sc[q] < m;
            recv_ok = rc[q] < rp[q] && rc[q] < m;
            if (send_ok || recv_ok) break;
            q = (q + 1) % NQ;
          end
          if (send_ok && !recv_ok) cmd = rcct_pkg::CMD_SEND_CPL;
          else if (recv_ok && !send_ok) cmd = rcct_pkg::CMD_RECV_CPL;
          if (cmd == rcct_pkg::CMD_SEND_CPL) sc[q]++;
          else rc[q]++;
          queue_request(cmd, q[0]);
        end
      end
      while (requests_taken != requests_queued) @(posedge clk_i);
    end
  endtask

  // Request driver: predicts on acceptance, then offers the next backlog entry.
  always @(posedge clk_i) begin
    if (!rst_n) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready_o) begin
        track_request(s_tuser, s_tdata[0]);
        requests_taken++;
      end
      if (!s_tvalid || s_tready_o) begin
        if (request_backlog.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          s_tvalid               <= 1'b1;
          {s_tdata[0], s_tuser}  <= request_backlog.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with the progress watchdog.
  always @(posedge clk_i) begin : result_monitor
    tracker_result_t got;
    tracker_result_t want;
    m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    if (rst_n && m_tvalid_o && m_tready) begin
      got = '{rcct_pkg::kind_e'(m_tuser_o), m_tdata_o[0], m_tdata_o[10:1], m_tdata_o[18:11],
              m_tlast_o};
      if (due_results.size() == 0) begin
        if (mismatches < 10) $display("unexpected result: %s", fmt_result(got));
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          if (mismatches < 10) begin
            $display("result mismatch: expected %s", fmt_result(want));
            $display("                 actual   %s", fmt_result(got));
          end
          mismatches++;
        end
      end
    end
    if ((s_tvalid && s_tready_o) || (m_tvalid_o && m_tready) || (cfg_valid && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_ring_collective_completion_tracker_top NOT OK");
      $finish;
    end
  end

  initial begin
    int                    deepest;
    logic [CFG_DATA_W-1:0] next_msgs;
    msgs_reg      = '0;
    send_peer_reg = 8'd1;
    recv_peer_reg = '0;
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    // The mark store is swept after reset; requests are taken once that is over.
    do @(posedge clk_i); while (!s_tready_o);

    write_reg(rcct_pkg::REG_MSGS_PER_QUEUE, '0);
    write_reg(rcct_pkg::REG_SEND_PEER, 11'd0);
    write_reg(rcct_pkg::REG_RECV_PEER, 11'd255);
    cfg_valid <= 1'b0;

    // With no messages: unused command, completions with nothing posted, an empty start.
    queue_request(CMD_UNUSED, 1'b0);
    queue_request(CMD_UNUSED, 1'b1);
    queue_request(rcct_pkg::CMD_SEND_CPL, 1'b0);
    queue_request(rcct_pkg::CMD_RECV_CPL, 1'b1);
    queue_request(rcct_pkg::CMD_START, 1'b1);
    wait_quiet();

    // Six messages: a full start, a refused restart, reposts of a receive and a send.
    write_reg(rcct_pkg::REG_MSGS_PER_QUEUE, 11'd6);
    write_reg(rcct_pkg::REG_SEND_PEER, 11'd255);
    write_reg(rcct_pkg::REG_RECV_PEER, 11'd0);
    cfg_valid <= 1'b0;
    queue_request(rcct_pkg::CMD_START, 1'b0);
    queue_request(rcct_pkg::CMD_START, 1'b1);
    queue_request(rcct_pkg::CMD_RECV_CPL, 1'b0);
    queue_request(rcct_pkg::CMD_SEND_CPL, 1'b0);
    queue_request(rcct_pkg::CMD_SEND_CPL, 1'b1);
    queue_request(rcct_pkg::CMD_RECV_CPL, 1'b1);
    queue_request(CMD_UNUSED, 1'b1);
    wait_quiet();

    // Random traffic until both queues finish, then spurious completions.
    run_traffic(60);
    wait_quiet();

    // Largest register value, capped to the store size; sender mostly idle.
    write_reg(rcct_pkg::REG_MSGS_PER_QUEUE, 11'd2047);
    write_reg(rcct_pkg::REG_SEND_PEER, 11'($urandom_range(0, 255)));
    write_reg(rcct_pkg::REG_RECV_PEER, 11'($urandom_range(0, 255)));
    cfg_valid <= 1'b0;
    sender_idle_pct = 75;
    run_traffic(90);
    wait_quiet();

    // Bring the message count just above the progress so far, so both queues finish again.
    deepest = 0;
    for (int q = 0; q < NQ; q++) begin
      if (sends_done[q] > deepest) deepest = sends_done[q];
      if (recvs_done[q] > deepest) deepest = recvs_done[q];
    end
    next_msgs = CFG_DATA_W'(deepest + 12);
    write_reg(rcct_pkg::REG_MSGS_PER_QUEUE, next_msgs);
    cfg_valid <= 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 75;
    run_traffic(80);
    wait_quiet();

    deepest = 0;
    for (int q = 0; q < NQ; q++) begin
      if (sends_done[q] > deepest) deepest = sends_done[q];
      if (recvs_done[q] > deepest) deepest = recvs_done[q];
    end
    next_msgs = CFG_DATA_W'(deepest + 8);
    write_reg(rcct_pkg::REG_MSGS_PER_QUEUE, next_msgs);
    write_reg(rcct_pkg::REG_SEND_PEER, 11'($urandom_range(0, 255)));
    write_reg(rcct_pkg::REG_RECV_PEER, 11'($urandom_range(0, 255)));
    cfg_valid <= 1'b0;
    sender_idle_pct    = 29;
    receiver_stall_pct = 29;
    run_traffic(70);
    wait_quiet();

    if (mismatches == 0)
      $display("tb_ring_collective_completion_tracker_top OK");
    else
      $display("tb_ring_collective_completion_tracker_top NOT OK");
    $finish;
  end

endmodule
